// ===== rtl/dpsl_pkg.sv =====
// Package: widths, register indexes, reset values and helpers for the speed/power limiter.
`timescale 1ns / 1ps
`default_nettype none

package dpsl_pkg;

    localparam int VALUE_WIDTH_DEF = 16;

    // Field widths
    localparam int PCT_W   = 15;  // unsigned Q7.8 percent
    localparam int MEAS_W  = 16;  // signed Q8.8 measurement
    localparam int KP_W    = 12;  // unsigned Q4.8
    localparam int KI_W    = 16;  // unsigned Q0.16
    localparam int ERR_W   = 18;  // setpoint minus measurement
    localparam int PI_W    = KI_W + 1 + ERR_W;  // integral product
    localparam int PP_W    = KP_W + 1 + ERR_W;  // proportional product
    localparam int ISTEP_W = PI_W - 16;
    localparam int PSTEP_W = PP_W - 8;
    localparam int ACC_W   = 24;  // sums before clamping

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PCT_W-1:0] FULL_SCALE = 15'd25600;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_TARGET = 3'd5;

    // Reset values
    localparam logic [KP_W-1:0]  PROP_GAIN_RST    = 12'd256;
    localparam logic [KI_W-1:0]  INTEG_GAIN_RST   = 16'd1311;
    localparam logic [PCT_W-1:0] DEAD_ZONE_RST    = 15'd2560;
    localparam logic [PCT_W-1:0] SPEED_MIN_RST    = 15'd2560;
    localparam logic [PCT_W-1:0] SPEED_MAX_RST    = 15'd8533;
    localparam logic [PCT_W-1:0] POWER_TARGET_RST = 15'd25600;

    typedef logic signed [ACC_W-1:0] acc_t;

    // Apply upper bound first, lower bound last
    function automatic acc_t clamp_hi_lo(input acc_t v, input acc_t lo, input acc_t hi);
        acc_t r;
        r = v;
        if (r > hi)
        begin
            r = hi;
        end
        if (r < lo)
        begin
            r = lo;
        end
        return r;
    endfunction

endpackage : dpsl_pkg

`default_nettype wire

// ===== rtl/dual_pi_speed_power_limiter.sv =====
// Top level: dual PI speed and power loops with min select and speed loop lock.
`timescale 1ns / 1ps
`default_nettype none

// One item is one control tick. It is taken into an input register. Both PI
// updates run through combinational logic into the result register, which is
// loaded from the input register once it is empty or its result is being taken.
// A new item is taken every cycle while m_tready is high. The integrators and
// lock are written in the cycle that the item is processed, so the next item
// always sees them. The input register can take one more item while a finished
// result waits on m_tready; once both are full the input stalls until the result
// is taken. Configuration is written through cfg_valid/cfg_index/cfg_data (always
// ready); unknown indexes are dropped.
module dual_pi_speed_power_limiter
    import dpsl_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // [14:0] speed_setpoint, [30:15] measured_speed, [46:31] measured_power
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // [14:0] drive_level, [29:15] speed_command, [44:30] power_command
    output      logic [OUT_DATA_W-1:0] m_tdata,
    // [0] power_limited
    output      logic                  m_tuser,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Stored values never exceed the 15-bit clamps nor the storage limit
    localparam int SW = (VALUE_WIDTH - 1 < PCT_W) ? VALUE_WIDTH - 1 : PCT_W;
    localparam acc_t STORE_MAX = acc_t'((64'd1 << SW) - 64'd1);

    // Configuration registers
    logic [KP_W-1:0]  prop_gain_reg;
    logic [KI_W-1:0]  integ_gain_reg;
    logic [PCT_W-1:0] dead_zone_reg;
    logic [PCT_W-1:0] speed_min_reg;
    logic [PCT_W-1:0] speed_max_reg;
    logic [PCT_W-1:0] power_target_reg;

    // Loop state
    logic [SW-1:0] speed_integral_reg, speed_integral_next;
    logic [SW-1:0] power_integral_reg, power_integral_next;
    logic [SW-1:0] speed_hold_reg, speed_hold_next;
    logic          speed_lock_reg, speed_lock_next;

    // Input and result registers
    logic              in_valid_reg;
    logic [PCT_W-1:0]  in_setpoint_reg;
    logic [MEAS_W-1:0] in_speed_reg;
    logic [MEAS_W-1:0] in_power_reg;

    logic              out_valid_reg;
    logic [PCT_W-1:0]  out_drive_reg, out_drive_next;
    logic              out_limited_reg, out_limited_next;
    logic [PCT_W-1:0]  out_speed_reg, out_speed_next;
    logic [PCT_W-1:0]  out_power_reg, out_power_next;

    logic process;

    assign cfg_ready = 1'b1;
    assign process   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || process;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_power_reg, out_speed_reg, out_drive_reg};
    assign m_tuser  = out_limited_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= PROP_GAIN_RST;
            integ_gain_reg   <= INTEG_GAIN_RST;
            dead_zone_reg    <= DEAD_ZONE_RST;
            speed_min_reg    <= SPEED_MIN_RST;
            speed_max_reg    <= SPEED_MAX_RST;
            power_target_reg <= POWER_TARGET_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:    prop_gain_reg    <= cfg_data[KP_W-1:0];
                REG_INTEG_GAIN:   integ_gain_reg   <= cfg_data[KI_W-1:0];
                REG_DEAD_ZONE:    dead_zone_reg    <= cfg_data[PCT_W-1:0];
                REG_SPEED_MIN:    speed_min_reg    <= cfg_data[PCT_W-1:0];
                REG_SPEED_MAX:    speed_max_reg    <= cfg_data[PCT_W-1:0];
                REG_POWER_TARGET: power_target_reg <= cfg_data[PCT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Speed loop arithmetic
    logic [PCT_W-1:0]         sp_eff;
    logic signed [ERR_W-1:0]  spd_err;
    logic signed [PI_W-1:0]   spd_iprod;
    logic signed [PP_W-1:0]   spd_pprod;
    logic signed [ISTEP_W-1:0] spd_istep;
    logic signed [PSTEP_W-1:0] spd_pstep;
    acc_t spd_isum, spd_iclamp, spd_out, spd_oclamp;

    // Power loop arithmetic
    logic signed [ERR_W-1:0]  pwr_err;
    logic signed [PI_W-1:0]   pwr_iprod;
    logic signed [PP_W-1:0]   pwr_pprod;
    logic signed [ISTEP_W-1:0] pwr_istep;
    logic signed [PSTEP_W-1:0] pwr_pstep;
    acc_t pwr_isum, pwr_iclamp, pwr_out, pwr_cmd;

    acc_t smin_a, smax_a, full_a;

    always_comb
    begin
        smin_a = acc_t'({1'b0, speed_min_reg});
        smax_a = acc_t'({1'b0, speed_max_reg});
        full_a = acc_t'({1'b0, FULL_SCALE});

        sp_eff    = (in_setpoint_reg < dead_zone_reg) ? '0 : in_setpoint_reg;
        spd_err   = ERR_W'(signed'({1'b0, sp_eff})) - ERR_W'(signed'(in_speed_reg));
        spd_iprod = signed'({1'b0, integ_gain_reg}) * spd_err;
        spd_pprod = signed'({1'b0, prop_gain_reg}) * spd_err;
        // Round half up: add half an LSB, then arithmetic shift
        spd_istep = ISTEP_W'((spd_iprod + PI_W'(signed'(33'sd32768))) >>> 16);
        spd_pstep = PSTEP_W'((spd_pprod + PP_W'(signed'(33'sd128))) >>> 8);
        spd_isum  = acc_t'(spd_istep) + acc_t'({1'b0, speed_integral_reg});
        spd_iclamp = clamp_hi_lo(clamp_hi_lo(spd_isum, smin_a, smax_a), '0, STORE_MAX);
        spd_out   = acc_t'(spd_pstep) + spd_iclamp;
        spd_oclamp = clamp_hi_lo(clamp_hi_lo(spd_out, smin_a, smax_a), '0, STORE_MAX);

        pwr_err   = ERR_W'(signed'({1'b0, power_target_reg})) - ERR_W'(signed'(in_power_reg));
        pwr_iprod = signed'({1'b0, integ_gain_reg}) * pwr_err;
        pwr_pprod = signed'({1'b0, prop_gain_reg}) * pwr_err;
        pwr_istep = ISTEP_W'((pwr_iprod + PI_W'(signed'(33'sd32768))) >>> 16);
        pwr_pstep = PSTEP_W'((pwr_pprod + PP_W'(signed'(33'sd128))) >>> 8);
        pwr_isum  = acc_t'(pwr_istep) + acc_t'({1'b0, power_integral_reg});
        pwr_iclamp = clamp_hi_lo(clamp_hi_lo(pwr_isum, '0, full_a), '0, STORE_MAX);
        pwr_out   = acc_t'(pwr_pstep) + pwr_iclamp;
        pwr_cmd   = clamp_hi_lo(pwr_out, '0, full_a);

        // Freeze the speed loop while locked
        if (speed_lock_reg)
        begin
            speed_integral_next = speed_integral_reg;
            speed_hold_next     = speed_hold_reg;
        end
        else
        begin
            speed_integral_next = spd_iclamp[SW-1:0];
            speed_hold_next     = spd_oclamp[SW-1:0];
        end
        power_integral_next = pwr_iclamp[SW-1:0];

        // Tie goes to the speed command
        if (acc_t'({1'b0, speed_hold_next}) <= pwr_cmd)
        begin
            speed_lock_next  = 1'b0;
            out_limited_next = 1'b0;
            out_drive_next   = PCT_W'(speed_hold_next);
        end
        else
        begin
            speed_lock_next  = 1'b1;
            out_limited_next = 1'b1;
            out_drive_next   = pwr_cmd[PCT_W-1:0];
        end
        out_speed_next = PCT_W'(speed_hold_next);
        out_power_next = pwr_cmd[PCT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            speed_integral_reg <= '0;
            power_integral_reg <= '0;
            speed_hold_reg     <= '0;
            speed_lock_reg     <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (process)
            begin
                out_valid_reg      <= 1'b1;
                speed_integral_reg <= speed_integral_next;
                power_integral_reg <= power_integral_next;
                speed_hold_reg     <= speed_hold_next;
                speed_lock_reg     <= speed_lock_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_setpoint_reg <= s_tdata[14:0];
            in_speed_reg    <= s_tdata[30:15];
            in_power_reg    <= s_tdata[46:31];
        end
        if (process)
        begin
            out_drive_reg   <= out_drive_next;
            out_limited_reg <= out_limited_next;
            out_speed_reg   <= out_speed_next;
            out_power_reg   <= out_power_next;
        end
    end

endmodule : dual_pi_speed_power_limiter

`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for the dual PI speed/power limiter: directed ticks, random ticks, stalls and checks.
`timescale 1ns / 1ps

module testbench;
    import dpsl_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_SLACK = 4;
    localparam int IDLE_PCT = 31;
    localparam longint STORE_MAX = 32767;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [PCT_W-1:0] drive;
        logic             limited;
        logic [PCT_W-1:0] speed_cmd;
        logic [PCT_W-1:0] power_cmd;
    } tick_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the registers and loop state
    logic [KP_W-1:0]  kp_reg;
    logic [KI_W-1:0]  ki_reg;
    logic [PCT_W-1:0] dead_zone_reg;
    logic [PCT_W-1:0] speed_min_reg;
    logic [PCT_W-1:0] speed_max_reg;
    logic [PCT_W-1:0] power_target_reg;
    longint           speed_integ;
    longint           power_integ;
    longint           speed_hold;
    logic             speed_locked;

    tick_result_t expected_ticks[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           src_idle_pct = IDLE_PCT;
    int           sink_idle_pct = IDLE_PCT;
    int           sink_stall_left = 0;
    tick_result_t want_res;
    tick_result_t got_res;

    dual_pi_speed_power_limiter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Round to nearest, ties toward plus infinity
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Upper bound first, lower bound last
    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        longint r;
        r = v;
        if (r > hi)
        begin
            r = hi;
        end
        if (r < lo)
        begin
            r = lo;
        end
        return r;
    endfunction

    function automatic tick_result_t run_control_tick(input logic [PCT_W-1:0] setpoint,
                                                      input logic signed [MEAS_W-1:0] speed,
                                                      input logic signed [MEAS_W-1:0] power);
        longint kpv;
        longint kiv;
        longint smin;
        longint smax;
        longint sp;
        longint err;
        longint outv;
        longint pcmd;
        tick_result_t r;
        kpv = kp_reg;
        kiv = ki_reg;
        smin = speed_min_reg;
        smax = speed_max_reg;
        if (!speed_locked)
        begin
            sp = setpoint;
            if (sp < longint'(dead_zone_reg))
            begin
                sp = 0;
            end
            err = sp - longint'(speed);
            speed_integ = clamp_range(speed_integ + round_shift(kiv * err, 16), smin, smax);
            speed_integ = clamp_range(speed_integ, 0, STORE_MAX);
            outv = round_shift(kpv * err, 8) + speed_integ;
            speed_hold = clamp_range(clamp_range(outv, smin, smax), 0, STORE_MAX);
        end
        err = longint'(power_target_reg) - longint'(power);
        power_integ = clamp_range(power_integ + round_shift(kiv * err, 16), 0, FULL_SCALE);
        power_integ = clamp_range(power_integ, 0, STORE_MAX);
        outv = round_shift(kpv * err, 8) + power_integ;
        pcmd = clamp_range(outv, 0, FULL_SCALE);
        // Tie goes to the speed loop and releases the lock
        speed_locked = (speed_hold > pcmd);
        r.limited = speed_locked;
        r.drive = speed_locked ? pcmd[PCT_W-1:0] : speed_hold[PCT_W-1:0];
        r.speed_cmd = speed_hold[PCT_W-1:0];
        r.power_cmd = pcmd[PCT_W-1:0];
        return r;
    endfunction

    task automatic reset_model();
        kp_reg = PROP_GAIN_RST;
        ki_reg = INTEG_GAIN_RST;
        dead_zone_reg = DEAD_ZONE_RST;
        speed_min_reg = SPEED_MIN_RST;
        speed_max_reg = SPEED_MAX_RST;
        power_target_reg = POWER_TARGET_RST;
        speed_integ = 0;
        power_integ = 0;
        speed_hold = 0;
        speed_locked = 1'b0;
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        end
    endtask

    // Result sink: random or held-off ready, compare each item against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_ticks.size() == 0)
            begin
                note_mismatch("unexpected result, queue depth", 0, 1);
            end
            else
            begin
                want_res = expected_ticks.pop_front();
                got_res.drive = m_tdata[14:0];
                got_res.speed_cmd = m_tdata[29:15];
                got_res.power_cmd = m_tdata[44:30];
                got_res.limited = m_tuser;
                if (want_res.drive != got_res.drive)
                begin
                    note_mismatch("drive_level", want_res.drive, got_res.drive);
                end
                if (want_res.limited != got_res.limited)
                begin
                    note_mismatch("power_limited", want_res.limited, got_res.limited);
                end
                if (want_res.speed_cmd != got_res.speed_cmd)
                begin
                    note_mismatch("speed_command", want_res.speed_cmd, got_res.speed_cmd);
                end
                if (want_res.power_cmd != got_res.power_cmd)
                begin
                    note_mismatch("power_command", want_res.power_cmd, got_res.power_cmd);
                end
            end
        end
        if (sink_stall_left > 0)
        begin
            sink_stall_left <= sink_stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= (int'($urandom_range(99)) >= sink_idle_pct);
        end
    end

    task automatic send_tick(input logic [PCT_W-1:0] setpoint,
                             input logic signed [MEAS_W-1:0] speed,
                             input logic signed [MEAS_W-1:0] power);
        while (int'($urandom_range(99)) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, power, speed, setpoint};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        expected_ticks.push_back(run_control_tick(setpoint, speed, power));
    endtask

    // Drop valid and hold until every predicted item has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_ticks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_PROP_GAIN:    kp_reg = data[KP_W-1:0];
            REG_INTEG_GAIN:   ki_reg = data[KI_W-1:0];
            REG_DEAD_ZONE:    dead_zone_reg = data[PCT_W-1:0];
            REG_SPEED_MIN:    speed_min_reg = data[PCT_W-1:0];
            REG_SPEED_MAX:    speed_max_reg = data[PCT_W-1:0];
            REG_POWER_TARGET: power_target_reg = data[PCT_W-1:0];
            default:          ;
        endcase
    endtask

    function automatic logic [PCT_W-1:0] pick_percent(input bit extreme);
        if (extreme)
        begin
            return $urandom_range(1) ? FULL_SCALE : '0;
        end
        return PCT_W'($urandom_range(25600));
    endfunction

    // Unused high bits of the write data carry noise; the register drops them
    task automatic write_random_config(input bit extreme);
        logic [KP_W-1:0] kp;
        logic [KI_W-1:0] ki;
        kp = extreme ? ($urandom_range(1) ? 12'hFFF : 12'h000) : KP_W'($urandom_range(4095));
        ki = extreme ? ($urandom_range(1) ? 16'hFFFF : 16'h0000) : KI_W'($urandom_range(65535));
        write_reg(REG_PROP_GAIN, {4'($urandom), kp});
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DEAD_ZONE, {1'($urandom), pick_percent(extreme)});
        write_reg(REG_SPEED_MIN, {1'($urandom), pick_percent(extreme)});
        write_reg(REG_SPEED_MAX, {1'($urandom), pick_percent(extreme)});
        write_reg(REG_POWER_TARGET, {1'($urandom), pick_percent(extreme)});
    endtask

    // Mostly measurements near the setpoints so the loops settle, some full-range noise
    task automatic send_random_tick();
        logic [PCT_W-1:0]         sp;
        logic signed [MEAS_W-1:0] spd;
        logic signed [MEAS_W-1:0] pwr;
        int                       off;
        sp = ($urandom_range(3) == 0) ? pick_percent(1'b0)
                                      : PCT_W'(dead_zone_reg + $urandom_range(600) - 300);
        if (sp > FULL_SCALE)
        begin
            sp = pick_percent(1'b0);
        end
        off = int'($urandom_range(4000)) - 2000;
        spd = ($urandom_range(9) < 6) ? 16'(int'(speed_hold) + off) : 16'($urandom);
        off = int'($urandom_range(6000)) - 3000;
        pwr = ($urandom_range(9) < 6) ? 16'(int'(power_target_reg) + off) : 16'($urandom);
        send_tick(sp, spd, pwr);
    endtask

    task automatic test_defaults();
        send_tick(15'd0, 16'sh0000, 16'sh0000);
        send_tick(FULL_SCALE, -16'sd32768, 16'sh7FFF);
        send_tick(FULL_SCALE, 16'sh7FFF, -16'sd32768);
        send_tick(15'h7FFF & FULL_SCALE, 16'sd1000, 16'sd25600);
        send_tick(15'd5000, 16'sd4000, 16'sd30000);
        send_tick(15'd5000, 16'sd4000, -16'sd1);
    endtask

    task automatic test_dead_zone();
        write_reg(REG_DEAD_ZONE, 16'd3000);
        send_tick(15'd2999, 16'sd0, 16'sd0);
        send_tick(15'd3000, 16'sd0, 16'sd0);
        send_tick(15'd0, -16'sd500, 16'sd0);
    endtask

    task automatic test_inverted_limits();
        write_reg(REG_SPEED_MIN, 16'd9000);
        write_reg(REG_SPEED_MAX, 16'd4000);
        send_tick(15'd20000, 16'sd0, 16'sd0);
        send_tick(15'd3500, 16'sd20000, 16'sd0);
    endtask

    // Pin the speed command at 5000 and steer the power command around it:
    // below it locks, a locked tick ignores the speed inputs, equal releases the lock
    task automatic test_lock_and_tie();
        write_reg(REG_PROP_GAIN, 16'd256);
        write_reg(REG_INTEG_GAIN, 16'd0);
        write_reg(REG_SPEED_MIN, 16'd5000);
        write_reg(REG_SPEED_MAX, 16'd5000);
        write_reg(REG_POWER_TARGET, 16'd0);
        send_tick(15'd8000, 16'sd0, 16'(int'(power_integ) - 4000));
        send_tick(FULL_SCALE, -16'sd32768, 16'(int'(power_integ) - 3000));
        send_tick(15'd8000, 16'sd0, 16'(int'(power_integ) - 5000));
        send_tick(15'd8000, 16'sd0, 16'(int'(power_integ) - 6000));
    endtask

    task automatic test_gain_extremes();
        write_reg(REG_PROP_GAIN, 16'hFFFF);
        write_reg(REG_INTEG_GAIN, 16'hFFFF);
        write_reg(REG_SPEED_MIN, 16'd0);
        write_reg(REG_SPEED_MAX, 16'd25600);
        write_reg(REG_POWER_TARGET, 16'd25600);
        send_tick(FULL_SCALE, -16'sd32768, -16'sd32768);
        send_tick(15'd0, 16'sh7FFF, 16'sh7FFF);
        write_reg(REG_PROP_GAIN, 16'd0);
        write_reg(REG_INTEG_GAIN, 16'd0);
        send_tick(FULL_SCALE, -16'sd32768, 16'sh7FFF);
    endtask

    task automatic test_spare_index();
        write_reg(REG_SPARE_6, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'h0000);
        send_tick(15'd12000, 16'sd100, 16'sd100);
    endtask

    task automatic test_random_ticks();
        for (int ph = 0; ph < 7; ph++)
        begin
            write_random_config(ph == 1 || ph == 4);
            for (int n = 0; n < 50; n++)
            begin
                send_random_tick();
            end
        end
    endtask

    task automatic test_streaming();
        write_random_config(1'b0);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        for (int n = 0; n < 50; n++)
        begin
            send_random_tick();
        end
        src_idle_pct = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
    endtask

    // Hold the sink off while the source keeps offering, so the input stalls
    task automatic test_backpressure();
        write_random_config(1'b0);
        src_idle_pct = 0;
        sink_stall_left = 200;
        for (int n = 0; n < 40; n++)
        begin
            send_random_tick();
        end
        src_idle_pct = IDLE_PCT;
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 10; n++)
        begin
            send_random_tick();
        end
        wait_drained();
        for (int n = 0; n < 10; n++)
        begin
            send_random_tick();
        end
    endtask

    initial
    begin
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_dead_zone();
        test_inverted_limits();
        test_lock_and_tie();
        test_gain_extremes();
        test_spare_index();
        test_random_ticks();
        test_streaming();
        test_backpressure();
        test_drain_pause();
        wait_drained();
        if (mismatch_count == 0 && expected_ticks.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
